/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int DIV_STEPS = 10;
	localparam int DIV_BPS = (32 + FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_W = DIV_STEPS * DIV_BPS;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [3:0] CMD_ADD = 4'd0;
	localparam logic [3:0] CMD_SUB = 4'd1;
	localparam logic [3:0] CMD_MUL = 4'd2;
	localparam logic [3:0] CMD_DIV = 4'd3;
	localparam logic [3:0] CMD_GT = 4'd4;
	localparam logic [3:0] CMD_LT = 4'd5;
	localparam logic [3:0] CMD_GE = 4'd6;
	localparam logic [3:0] CMD_LE = 4'd7;
	localparam logic [3:0] CMD_EQ = 4'd8;
	localparam logic [3:0] CMD_NE = 4'd9;
	localparam logic [3:0] CMD_INC = 4'd10;
	localparam logic [3:0] CMD_DEC = 4'd11;
	localparam logic [3:0] CMD_MIN = 4'd12;
	localparam logic [3:0] CMD_MAX = 4'd13;
	localparam logic [3:0] CMD_FROM_INT = 4'd14;
	localparam logic [3:0] CMD_TO_INT = 4'd15;

	typedef enum logic [1:0] {
		CLS_SIMPLE,
		CLS_MUL,
		CLS_DIV
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [31:0]       simple_value;
		logic              compare_true;
		logic              divide_by_zero;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} op_t;
endpackage

/* rtl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// One item per cycle sustained while the output is not stalled. A front stage
// registers each item and does add, sub, compare, min/max, inc/dec and
// conversions; a four-deep queue feeds the back pipeline, where a registered
// 32x32 multiplier and a divider of ten stages (four quotient bits each)
// finish every item. A waiting result freezes the back pipeline and the queue
// absorbs the front.
module fixed_point_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         command,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic               compare_true,
	output logic               divide_by_zero
);
	import fpa_pkg::*;

	op_t  f_op;
	op_t  q_op;
	logic f_valid;
	logic f_ready;
	logic q_valid;
	logic q_ready;

	fpa_front u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .command,
		.operand_a, .operand_b, .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	fpa_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_op(f_op),
		.out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
	);

	fpa_back u_back (
		.clk, .arst_n, .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
		.out_valid, .ready(out_ready), .value, .compare_true, .divide_by_zero
	);
endmodule

/* rtl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Accepts items, classifies them and computes the single-cycle operations.
// ----------------------------------------------------------------------------
module fpa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic [3:0]         command,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               op_valid,
	input  logic               op_ready,
	output fpa_pkg::op_t       op
);
	import fpa_pkg::*;

	op_t  op_q;
	logic vld_q;
	op_t  nxt;
	logic lt;
	logic eq;

	assign lt = operand_a < operand_b;
	assign eq = operand_a == operand_b;
	assign ready = !vld_q || op_ready;

	always_comb begin
		nxt = '0;
		nxt.cls = CLS_SIMPLE;
		nxt.a = operand_a;
		nxt.b = operand_b;
		unique case (command)
			CMD_ADD: nxt.simple_value = operand_a + operand_b;
			CMD_SUB: nxt.simple_value = operand_a - operand_b;
			CMD_MUL: nxt.cls = CLS_MUL;
			CMD_DIV: begin
				if (operand_b == 0) nxt.divide_by_zero = 1'b1;
				else nxt.cls = CLS_DIV;
			end
			CMD_GT: nxt.compare_true = !lt && !eq;
			CMD_LT: nxt.compare_true = lt;
			CMD_GE: nxt.compare_true = !lt;
			CMD_LE: nxt.compare_true = lt || eq;
			CMD_EQ: nxt.compare_true = eq;
			CMD_NE: nxt.compare_true = !eq;
			CMD_INC: nxt.simple_value = operand_a + 32'sd1;
			CMD_DEC: nxt.simple_value = operand_a - 32'sd1;
			CMD_MIN: nxt.simple_value = lt ? operand_a : operand_b;
			CMD_MAX: nxt.simple_value = (!lt && !eq) ? operand_a : operand_b;
			CMD_FROM_INT: nxt.simple_value = operand_a <<< FRAC_BITS;
			CMD_TO_INT: nxt.simple_value = operand_a >>> FRAC_BITS;
			default: nxt.simple_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ready) begin
			vld_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) op_q <= nxt;
	end

	assign op_valid = vld_q;
	assign op = op_q;
endmodule

/* rtl/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module fpa_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  fpa_pkg::op_t in_op,
	output logic         out_valid,
	input  logic         out_ready,
	output fpa_pkg::op_t out_op
);
	import fpa_pkg::*;

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign in_ready = cnt_q != QDEPTH[QPTR_W:0];
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_op = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_op;
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH[QPTR_W:0]) else $error("queue overfilled");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_q == rd_q) else $error("queue pointers");
`endif
endmodule

/* rtl/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Pipelined multiplier and radix-2 divider; merges results in order.
// ----------------------------------------------------------------------------
module fpa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  fpa_pkg::op_t       op,
	output logic               out_valid,
	input  logic               ready,
	output logic signed [31:0] value,
	output logic               compare_true,
	output logic               divide_by_zero
);
	import fpa_pkg::*;

	localparam int NST = DIV_STEPS + 2;

	// per-stage state: sign, |dividend| shifting out, remainder, quotient shifting in behind it
	logic               v_s [NST+1];
	op_t                o_s [NST+1];
	logic signed [63:0] prod_s [NST+1];
	logic [DIV_W-1:0]   dvd_s [NST+1];
	logic [31:0]        dvs_s [NST+1];
	logic [32:0]        rem_s [NST+1];
	logic               neg_s [NST+1];
	logic               adv;

	assign adv = !out_valid || ready;
	assign op_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= op_valid;
			for (int i = 2; i <= NST; i++) v_s[i] <= v_s[i-1];
		end
	end

	logic [DIV_W-1:0] adv0;
	logic [31:0]      bv0;
	always_comb begin
		adv0 = op.a[31] ? DIV_W'(-{{FRAC_BITS{op.a[31]}}, op.a})
			: DIV_W'({op.a, {FRAC_BITS{1'b0}}});
		adv0 = op.a[31] ? DIV_W'(-($signed({{FRAC_BITS{op.a[31]}}, op.a}) <<< FRAC_BITS))
			: adv0;
		bv0 = op.b[31] ? 32'(-op.b) : op.b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s[1] <= op;
			prod_s[1] <= 64'(op.a * op.b);
			dvd_s[1] <= adv0;
			dvs_s[1] <= bv0;
			rem_s[1] <= '0;
			neg_s[1] <= op.a[31] ^ op.b[31];
		end
	end

	genvar g;
	for (g = 1; g <= DIV_STEPS; g++) begin : g_div
		logic [DIV_W-1:0] d;
		logic [32:0]      r;
		always_comb begin
			d = dvd_s[g];
			r = rem_s[g];
			for (int k = 0; k < DIV_BPS; k++) begin
				r = {r[31:0], d[DIV_W-1]};
				d = {d[DIV_W-2:0], 1'b0};
				if (r >= {1'b0, dvs_s[g]}) begin
					r = r - {1'b0, dvs_s[g]};
					d[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				o_s[g+1] <= o_s[g];
				prod_s[g+1] <= prod_s[g];
				dvd_s[g+1] <= d;
				dvs_s[g+1] <= dvs_s[g];
				rem_s[g+1] <= r;
				neg_s[g+1] <= neg_s[g];
			end
		end
	end

	logic [31:0] q;
	always_comb begin
		q = neg_s[DIV_STEPS+1] ? 32'(-dvd_s[DIV_STEPS+1]) : 32'(dvd_s[DIV_STEPS+1]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s[NST] <= o_s[NST-1];
			prod_s[NST] <= prod_s[NST-1];
			dvd_s[NST] <= dvd_s[NST-1];
			dvs_s[NST] <= dvs_s[NST-1];
			rem_s[NST] <= rem_s[NST-1];
			neg_s[NST] <= neg_s[NST-1];
			unique case (o_s[NST-1].cls)
				CLS_MUL: value <= 32'(prod_s[NST-1] >>> FRAC_BITS);
				CLS_DIV: value <= q;
				default: value <= o_s[NST-1].simple_value;
			endcase
			compare_true <= o_s[NST-1].compare_true;
			divide_by_zero <= o_s[NST-1].divide_by_zero;
		end
	end

	assign out_valid = v_s[NST];

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ready |=> out_valid && $stable(value)) else $error("result lost");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> value == '0 && !compare_true)
		else $error("divide by zero value");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> v_s[1]) else $error("stage one missed");
`endif
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the fixed-point ALU: a directed table of corner items, then random
// items with random idling on both sides until a calm tail, every result
// compared against a fixed expected value or a local model of the arithmetic.
// ----------------------------------------------------------------------------
module tb;
	import fpa_pkg::*;

	localparam int N_RANDOM = 1830;
	localparam int CALM_TAIL = 200;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		logic [3:0]         cmd;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit                 fixed;
		logic signed [31:0] val;
		logic               cmp;
		logic               dz;
	} row_t;

	typedef struct {
		logic signed [31:0] val;
		logic               cmp;
		logic               dz;
	} alu_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         command;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value;
	logic               compare_true;
	logic               divide_by_zero;

	alu_result_t pending_results[$];
	row_t        directed_rows[$];
	int          mismatches;
	bit          calm;
	longint      cycles = 0;

	fixed_point_alu uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .compare_true(compare_true), .divide_by_zero(divide_by_zero)
	);

	function automatic alu_result_t compute_alu(logic [3:0] cmd, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_result_t r;
		longint sa;
		longint sb;
		longint res;
		sa = a;
		sb = b;
		res = 0;
		r.cmp = 1'b0;
		r.dz = 1'b0;
		case (cmd)
			CMD_ADD: res = sa + sb;
			CMD_SUB: res = sa - sb;
			CMD_MUL: res = (sa * sb) >>> FRAC_BITS;
			CMD_DIV: begin
				if (sb == 0) r.dz = 1'b1;
				else res = (sa * (longint'(1) << FRAC_BITS)) / sb;
			end
			CMD_GT: r.cmp = sa > sb;
			CMD_LT: r.cmp = sa < sb;
			CMD_GE: r.cmp = sa >= sb;
			CMD_LE: r.cmp = sa <= sb;
			CMD_EQ: r.cmp = sa == sb;
			CMD_NE: r.cmp = sa != sb;
			CMD_INC: res = sa + 1;
			CMD_DEC: res = sa - 1;
			CMD_MIN: res = (sa < sb) ? sa : sb;
			CMD_MAX: res = (sa > sb) ? sa : sb;
			CMD_FROM_INT: res = sa * (longint'(1) << FRAC_BITS);
			default: res = sa >>> FRAC_BITS;
		endcase
		r.val = res[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 0;
			3: return $signed($urandom_range(0, 4096)) - 2048;
			4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $urandom();
		endcase
	endfunction

	task automatic add_row(logic [3:0] cmd, logic signed [31:0] a, logic signed [31:0] b,
			bit fixed = 0, logic signed [31:0] val = 0, logic cmp = 0, logic dz = 0);
		row_t r;
		r.cmd = cmd;
		r.a = a;
		r.b = b;
		r.fixed = fixed;
		r.val = val;
		r.cmp = cmp;
		r.dz = dz;
		directed_rows.push_back(r);
	endtask

	task automatic send_item(logic [3:0] cmd, logic signed [31:0] a, logic signed [31:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// check results
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: value %h", value);
			end else begin
				alu_result_t e;
				e = pending_results.pop_front();
				if (value !== e.val || compare_true !== e.cmp || divide_by_zero !== e.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%b/%b got %h/%b/%b",
							e.val, e.cmp, e.dz, value, compare_true, divide_by_zero);
				end
			end
		end
	end

	// drive out_ready
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	initial begin
		alu_result_t exp;
		int wait_cycles;
		mismatches = 0;
		calm = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_ADD;
		operand_a = 0;
		operand_b = 0;

		add_row(CMD_ADD, 32'sh7fff_ffff, 1, 1, 32'sh8000_0000);
		add_row(CMD_SUB, 32'sh8000_0000, 1, 1, 32'sh7fff_ffff);
		add_row(CMD_MUL, 32'sh0000_0100, 32'sh0000_0100, 1, 32'sh0000_0100);
		add_row(CMD_MUL, -1, 1, 1, -1);
		add_row(CMD_MUL, 32'sh8000_0000, 32'sh8000_0000);
		add_row(CMD_MUL, 32'sh7fff_ffff, 32'sh8000_0000);
		add_row(CMD_DIV, 32'sh1234_5678, 0, 1, 0, 0, 1);
		add_row(CMD_DIV, 32'sh8000_0000, -1);
		add_row(CMD_DIV, -1, 3);
		add_row(CMD_DIV, 32'sh7fff_ffff, 1);
		add_row(CMD_GT, 5, 5, 1, 0, 0);
		add_row(CMD_LT, 32'sh8000_0000, 32'sh7fff_ffff, 1, 0, 1);
		add_row(CMD_GE, 5, 5, 1, 0, 1);
		add_row(CMD_LE, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0, 0);
		add_row(CMD_EQ, -1, -1, 1, 0, 1);
		add_row(CMD_NE, -1, -1, 1, 0, 0);
		add_row(CMD_INC, 32'sh7fff_ffff, 0, 1, 32'sh8000_0000);
		add_row(CMD_DEC, 32'sh8000_0000, -1, 1, 32'sh7fff_ffff);
		add_row(CMD_MIN, 7, 7);
		add_row(CMD_MAX, 32'sh8000_0000, 32'sh7fff_ffff, 1, 32'sh7fff_ffff);
		add_row(CMD_FROM_INT, 32'sh0080_0000, 0, 1, 32'sh8000_0000);
		add_row(CMD_TO_INT, -1, 0, 1, -1);
		add_row(CMD_TO_INT, 32'sh7fff_ffff, 0, 1, 32'sh007f_ffff);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].fixed) begin
				exp.val = directed_rows[i].val;
				exp.cmp = directed_rows[i].cmp;
				exp.dz = directed_rows[i].dz;
			end else begin
				exp = compute_alu(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b);
			end
			pending_results.push_back(exp);
			send_item(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			logic [3:0] c;
			logic signed [31:0] a;
			logic signed [31:0] b;
			if (n == N_RANDOM - CALM_TAIL) calm = 1;
			c = $urandom_range(0, 15);
			a = rand_operand();
			b = ($urandom_range(0, 5) == 0) ? a : rand_operand();
			pending_results.push_back(compute_alu(c, a, b));
			send_item(c, a, b);
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
bench/tb.sv
